@@ rtl/dnt_pkg.sv @@
// ----------------------------------------------------------------------------
// dnt_pkg
// Shared types and constants of the directory name table.
// ----------------------------------------------------------------------------
`default_nettype none

package dnt_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int NAME_BYTES_DEF = 9;
  localparam int OP_W           = 2;
  localparam int KEY_LOW_W      = 64;
  localparam int KEY_HIGH_W     = 8;
  localparam int SECTOR_W       = 10;
  localparam int SLOT_W         = 4;
  localparam int MAX_NAME_BYTES = 9;
  localparam int ENTRY_W        = KEY_LOW_W + KEY_HIGH_W + SECTOR_W;

  typedef enum logic [OP_W-1:0] {
    OP_FIND    = 2'd0,
    OP_ADD     = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_RLOOKUP = 2'd3
  } op_t;

  typedef struct packed {
    logic                  success;
    logic [SLOT_W-1:0]     slot;
    logic [SECTOR_W-1:0]   sector;
    logic [KEY_LOW_W-1:0]  found_low;
    logic [KEY_HIGH_W-1:0] found_high;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/dnt_ram.sv @@
// ----------------------------------------------------------------------------
// dnt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/dnt_norm.sv @@
// ----------------------------------------------------------------------------
// dnt_norm
// Key normalizer: zeroes every byte from the first zero byte, or from
// NAME_BYTES on.
// ----------------------------------------------------------------------------
`default_nettype none

module dnt_norm #(
  parameter int NAME_BYTES = dnt_pkg::NAME_BYTES_DEF
) (
  input  wire logic [dnt_pkg::KEY_LOW_W-1:0]  key_low,
  input  wire logic [dnt_pkg::KEY_HIGH_W-1:0] key_high,
  output logic      [dnt_pkg::KEY_LOW_W-1:0]  norm_low,
  output logic      [dnt_pkg::KEY_HIGH_W-1:0] norm_high
);

  localparam int KEY_W = dnt_pkg::KEY_LOW_W + dnt_pkg::KEY_HIGH_W;

  always_comb begin
    logic             ended;
    logic [7:0]       b;
    logic [KEY_W-1:0] key_all;
    logic [KEY_W-1:0] norm_all;
    ended    = 1'b0;
    key_all  = {key_high, key_low};
    norm_all = '0;
    for (int i = 0; i < dnt_pkg::MAX_NAME_BYTES; i++) begin
      b = key_all[8*i +: 8];
      if (i >= NAME_BYTES || b == 8'd0) begin
        ended = 1'b1;
      end
      if (ended) begin
        b = 8'd0;
      end
      norm_all[8*i +: 8] = b;
    end
    norm_low  = norm_all[dnt_pkg::KEY_LOW_W-1:0];
    norm_high = norm_all[KEY_W-1:dnt_pkg::KEY_LOW_W];
  end

endmodule

`default_nettype wire

@@ rtl/dnt_ctrl.sv @@
// ----------------------------------------------------------------------------
// dnt_ctrl
// Scan sequencer: walks the entry RAM one entry a cycle, keeps the valid
// marks, and commits add / remove at the end of the request.
// ----------------------------------------------------------------------------
`default_nettype none

module dnt_ctrl #(
  parameter int ENTRIES = dnt_pkg::ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           req_vld,
  output logic                                req_rdy,
  input  wire logic [dnt_pkg::OP_W-1:0]       req_op,
  input  wire logic [dnt_pkg::KEY_LOW_W-1:0]  req_low,
  input  wire logic [dnt_pkg::KEY_HIGH_W-1:0] req_high,
  input  wire logic [dnt_pkg::SECTOR_W-1:0]   req_sector,
  output logic                                res_vld,
  input  wire logic                           res_rdy,
  output dnt_pkg::result_t                    res
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KL_W  = dnt_pkg::KEY_LOW_W;
  localparam int KH_W  = dnt_pkg::KEY_HIGH_W;
  localparam int SC_W  = dnt_pkg::SECTOR_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  dnt_pkg::op_t              op_r;
  logic [KL_W-1:0]           key_low_r;
  logic [KH_W-1:0]           key_high_r;
  logic [SC_W-1:0]           sec_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      cmp_vld_r;
  logic [IDX_W-1:0]          cmp_idx_r;
  logic                      free_vld_r;
  logic [IDX_W-1:0]          free_idx_r;
  logic                      hit_r;
  logic [IDX_W-1:0]          hit_idx_r;
  logic [SC_W-1:0]           hit_sector_r;
  logic [KL_W-1:0]           hit_low_r;
  logic [KH_W-1:0]           hit_high_r;
  logic [ENTRIES-1:0]        valid_r;

  logic                      accept;
  logic                      issue;
  logic                      ent_v;
  logic                      match;
  logic                      last;
  logic                      commit;
  logic                      add_ok;
  logic [IDX_W-1:0]          res_idx;
  logic [dnt_pkg::ENTRY_W-1:0] rdata;
  logic [KL_W-1:0]           rd_low;
  logic [KH_W-1:0]           rd_high;
  logic [SC_W-1:0]           rd_sector;

  assign accept  = req_vld && req_rdy;
  assign req_rdy = (state_r == ST_IDLE);
  assign issue   = (state_r == ST_SCAN) && (cnt_r < CNT_W'(ENTRIES));

  assign {rd_low, rd_high, rd_sector} = rdata;

  assign ent_v = valid_r[cmp_idx_r];
  assign match = cmp_vld_r && ent_v &&
                 ((op_r == dnt_pkg::OP_RLOOKUP) ? (rd_sector == sec_r)
                                                : (rd_low == key_low_r &&
                                                   rd_high == key_high_r));
  assign last  = cmp_vld_r && (cmp_idx_r == IDX_W'(ENTRIES - 1));

  assign add_ok  = (op_r == dnt_pkg::OP_ADD) && !hit_r && free_vld_r;
  assign res_vld = (state_r == ST_FIN);
  assign commit  = res_vld && res_rdy;
  assign res_idx = (op_r == dnt_pkg::OP_ADD) ? free_idx_r : hit_idx_r;

  always_comb begin
    res            = '0;
    res.success    = (op_r == dnt_pkg::OP_ADD) ? add_ok : hit_r;
    res.slot       = res.success ? dnt_pkg::SLOT_W'(res_idx) : '0;
    res.sector     = (op_r == dnt_pkg::OP_FIND && hit_r) ? hit_sector_r : '0;
    res.found_low  = (op_r == dnt_pkg::OP_RLOOKUP && hit_r) ? hit_low_r : '0;
    res.found_high = (op_r == dnt_pkg::OP_RLOOKUP && hit_r) ? hit_high_r : '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_rdy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      valid_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= issue;
      if (commit && add_ok) begin
        valid_r[free_idx_r] <= 1'b1;
      end else if (commit && op_r == dnt_pkg::OP_REMOVE && hit_r) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= dnt_pkg::op_t'(req_op);
      key_low_r  <= req_low;
      key_high_r <= req_high;
      sec_r      <= req_sector;
      cnt_r      <= '0;
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (state_r == ST_SCAN && cmp_vld_r) begin
        if (!ent_v && !free_vld_r) begin
          free_vld_r <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
        if (match) begin
          hit_r        <= 1'b1;
          hit_idx_r    <= cmp_idx_r;
          hit_sector_r <= rd_sector;
          hit_low_r    <= rd_low;
          hit_high_r   <= rd_high;
        end
      end
    end
    if (issue) begin
      cmp_idx_r <= cnt_r[IDX_W-1:0];
    end
  end

  dnt_ram #(
    .WIDTH (dnt_pkg::ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (commit && add_ok),
    .waddr (free_idx_r),
    .wdata ({key_low_r, key_high_r, sec_r}),
    .re    (issue),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

@@ rtl/directory_name_table.sv @@
// ----------------------------------------------------------------------------
// directory_name_table
// Fixed table of named entries: find, add, remove and reverse lookup by
// sector, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when the block is idle and scans the entry RAM one entry
// per cycle, stopping at the first match (an add with no duplicate scans every
// entry); the single read port of the entry RAM sets this rate. Add and
// remove commit when the result moves into the output register, which lets
// the next request start while the result still waits on out_ready. Valid
// marks sit in flip-flops and clear at reset, so no clearing pass is needed.
`default_nettype none

module directory_name_table #(
  parameter int ENTRIES    = dnt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = dnt_pkg::NAME_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dnt_pkg::OP_W-1:0]       in_op,
  input  wire logic [dnt_pkg::KEY_LOW_W-1:0]  in_key_low,
  input  wire logic [dnt_pkg::KEY_HIGH_W-1:0] in_key_high,
  input  wire logic [dnt_pkg::SECTOR_W-1:0]   in_sector_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_success,
  output logic      [dnt_pkg::SLOT_W-1:0]     out_slot,
  output logic      [dnt_pkg::SECTOR_W-1:0]   out_sector_out,
  output logic      [dnt_pkg::KEY_LOW_W-1:0]  out_found_low,
  output logic      [dnt_pkg::KEY_HIGH_W-1:0] out_found_high
);

  logic [dnt_pkg::KEY_LOW_W-1:0]  norm_low;
  logic [dnt_pkg::KEY_HIGH_W-1:0] norm_high;
  logic                           res_vld;
  logic                           res_rdy;
  dnt_pkg::result_t               res;
  dnt_pkg::result_t               out_res_r;
  logic                           out_valid_r;

  dnt_norm #(
    .NAME_BYTES (NAME_BYTES)
  ) u_norm (
    .key_low   (in_key_low),
    .key_high  (in_key_high),
    .norm_low  (norm_low),
    .norm_high (norm_high)
  );

  dnt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_vld    (in_valid),
    .req_rdy    (in_ready),
    .req_op     (in_op),
    .req_low    (norm_low),
    .req_high   (norm_high),
    .req_sector (in_sector_in),
    .res_vld    (res_vld),
    .res_rdy    (res_rdy),
    .res        (res)
  );

  assign res_rdy = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_rdy) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_success    = out_res_r.success;
  assign out_slot       = out_res_r.slot;
  assign out_sector_out = out_res_r.sector;
  assign out_found_low  = out_res_r.found_low;
  assign out_found_high = out_res_r.found_high;

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_vld)
    else $error("result pending while idle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken during scan");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_success) |-> (out_slot == '0 && out_sector_out == '0 &&
      out_found_low == '0 && out_found_high == '0))
    else $error("failed result carries data");

  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && !res_rdy) |=> res_vld)
    else $error("result dropped before handoff");

endmodule

`default_nettype wire
